>>> src/cap_pkg.sv
// Shared constants, payload types and fixed-point helpers for the comb/allpass reverb.
`default_nettype none

package cap_pkg;

  // Channel count and per-channel store depths
  localparam int CHANNELS      = 2;
  localparam int COMB_A_DEPTH  = 2048;
  localparam int COMB_B_DEPTH  = 4096;
  localparam int ALLPASS_DEPTH = 512;

  // Field and datapath widths
  localparam int SampleW = 16;
  localparam int DataW   = 24;
  localparam int CoefW   = 17;
  localparam int FbW     = 16;
  localparam int MulAW   = 25;
  localparam int MulBW   = 18;
  localparam int ProdW   = MulAW + MulBW;
  localparam int AccW    = ProdW + 1;
  localparam int LanesW  = 2;

  // Register widths
  localparam int RoomW = 17;
  localparam int DampW = 17;
  localparam int MixW  = 17;
  localparam int LenAW = 12;
  localparam int LenBW = 13;
  localparam int LenPW = 10;

  localparam int ChanW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Position and memory address widths
  localparam int PosAW  = $clog2(COMB_A_DEPTH);
  localparam int PosBW  = $clog2(COMB_B_DEPTH);
  localparam int PosPW  = $clog2(ALLPASS_DEPTH);
  localparam int MemADepth = COMB_A_DEPTH * CHANNELS;
  localparam int MemBDepth = COMB_B_DEPTH * CHANNELS;
  localparam int MemPDepth = ALLPASS_DEPTH * CHANNELS;
  localparam int AddrAW = $clog2(MemADepth);
  localparam int AddrBW = $clog2(MemBDepth);
  localparam int AddrPW = $clog2(MemPDepth);

  function automatic int max2(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // Width for comparing positions against lengths and depths
  localparam int LenCmpW = max2(max2(max2(PosAW, PosBW), PosPW) + 1,
                                max2(max2(LenAW, LenBW), LenPW));

  // Clearing pass covers the largest store
  localparam int ClrLen = max2(max2(MemADepth, MemBDepth), MemPDepth);
  localparam int ClrW   = $clog2(ClrLen);

  // Frame queue between front and back
  localparam int QDepth = 2;
  localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW  = $clog2(QDepth + 1);

  // Coefficient constants
  localparam logic [CoefW-1:0] Q16One = CoefW'(65536);
  localparam logic [FbW-1:0]   FbBase = FbW'(45875);
  localparam logic [31:0]      FbSpan = 32'd18350;

  // Saturation bounds
  localparam logic signed [AccW-1:0] S24Hi = AccW'(8388607);
  localparam logic signed [AccW-1:0] S24Lo = AccW'(-8388608);
  localparam logic signed [AccW-1:0] S16Hi = AccW'(32767);
  localparam logic signed [AccW-1:0] S16Lo = AccW'(-32768);
  localparam logic signed [AccW-1:0] RndHalf = AccW'(32768);

  // Configuration port
  localparam int ApbDataW = 32;
  localparam int PaddrW   = 5;
  localparam int RegIdxW  = PaddrW - 2;

  localparam logic [RegIdxW-1:0] RegRoom    = RegIdxW'(0);
  localparam logic [RegIdxW-1:0] RegDamp    = RegIdxW'(1);
  localparam logic [RegIdxW-1:0] RegMix     = RegIdxW'(2);
  localparam logic [RegIdxW-1:0] RegLenA    = RegIdxW'(3);
  localparam logic [RegIdxW-1:0] RegLenB    = RegIdxW'(4);
  localparam logic [RegIdxW-1:0] RegLenP    = RegIdxW'(5);

  localparam logic [LenAW-1:0] LenAReset = LenAW'(1728);
  localparam logic [LenBW-1:0] LenBReset = LenBW'(2256);
  localparam logic [LenPW-1:0] LenPReset = LenPW'(384);

  typedef struct packed {
    logic signed [SampleW-1:0] left_in;
    logic signed [SampleW-1:0] right_in;
  } in_frame_t;

  typedef struct packed {
    logic signed [SampleW-1:0] left_out;
    logic signed [SampleW-1:0] right_out;
  } out_frame_t;

  typedef struct packed {
    logic [CoefW-1:0] damp;
    logic [CoefW-1:0] one_minus_damp;
    logic [CoefW-1:0] mix;
    logic [CoefW-1:0] one_minus_mix;
    logic [FbW-1:0]   fb;
    logic [LenAW-1:0] len_a;
    logic [LenBW-1:0] len_b;
    logic [LenPW-1:0] len_p;
  } cap_cfg_t;

  typedef struct packed {
    logic clearing;
  } cap_status_t;

  // Round half up and drop 16 fraction bits
  function automatic logic signed [AccW-1:0] rnd16(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] t;
    t = v + RndHalf;
    return t >>> 16;
  endfunction

  function automatic logic signed [DataW-1:0] sat24(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] t;
    t = (v > S24Hi) ? S24Hi : ((v < S24Lo) ? S24Lo : v);
    return t[DataW-1:0];
  endfunction

  function automatic logic signed [SampleW-1:0] sat16(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] t;
    t = (v > S16Hi) ? S16Hi : ((v < S16Lo) ? S16Lo : v);
    return t[SampleW-1:0];
  endfunction

  // Step a delay position, wrapping at the clamped length
  function automatic logic [LenCmpW-1:0] next_pos(input logic [LenCmpW-1:0] pos,
                                                  input logic [LenCmpW-1:0] len,
                                                  input logic [LenCmpW-1:0] depth);
    logic [LenCmpW-1:0] le;
    logic [LenCmpW-1:0] p1;
    le = (len == '0) ? LenCmpW'(1) : ((len > depth) ? depth : len);
    p1 = pos + LenCmpW'(1);
    return (p1 >= le) ? '0 : p1;
  endfunction

endpackage

`default_nettype wire

>>> src/cap_cfg_regs.sv
// APB-style configuration registers and derived coefficients.
`default_nettype none

module cap_cfg_regs
  import cap_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [PaddrW-1:0]   paddr,
  input  wire logic [ApbDataW-1:0] pwdata,
  output logic      [ApbDataW-1:0] prdata,
  output logic                     pready,
  output cap_cfg_t                 cfg_o
);

  logic [RoomW-1:0] room_q;
  logic [DampW-1:0] damp_q;
  logic [MixW-1:0]  mix_q;
  logic [LenAW-1:0] len_a_q;
  logic [LenBW-1:0] len_b_q;
  logic [LenPW-1:0] len_p_q;
  logic [FbW-1:0]   fb_q, fb_d;
  logic [CoefW-1:0] room_c, damp_c, mix_c;
  logic [31:0]      room_prod;
  logic             wr_en;
  logic [RegIdxW-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[PaddrW-1:2];

  // Write registers on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      room_q  <= '0;
      damp_q  <= '0;
      mix_q   <= '0;
      len_a_q <= LenAReset;
      len_b_q <= LenBReset;
      len_p_q <= LenPReset;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegRoom: room_q  <= pwdata[RoomW-1:0];
        RegDamp: damp_q  <= pwdata[DampW-1:0];
        RegMix:  mix_q   <= pwdata[MixW-1:0];
        RegLenA: len_a_q <= pwdata[LenAW-1:0];
        RegLenB: len_b_q <= pwdata[LenBW-1:0];
        RegLenP: len_p_q <= pwdata[LenPW-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      RegRoom: prdata = ApbDataW'(room_q);
      RegDamp: prdata = ApbDataW'(damp_q);
      RegMix:  prdata = ApbDataW'(mix_q);
      RegLenA: prdata = ApbDataW'(len_a_q);
      RegLenB: prdata = ApbDataW'(len_b_q);
      RegLenP: prdata = ApbDataW'(len_p_q);
      default: prdata = '0;
    endcase
  end

  // Clamp fractions to one
  assign room_c = (room_q > Q16One) ? Q16One : room_q;
  assign damp_c = (damp_q > Q16One) ? Q16One : damp_q;
  assign mix_c  = (mix_q  > Q16One) ? Q16One : mix_q;

  // Comb feedback 0.7 + 0.28 * room, registered after the multiply
  assign room_prod = 32'(room_c) * FbSpan;
  assign fb_d      = FbBase + room_prod[31:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_q <= FbBase;
    end else begin
      fb_q <= fb_d;
    end
  end

  assign cfg_o.damp           = damp_c;
  assign cfg_o.one_minus_damp = Q16One - damp_c;
  assign cfg_o.mix            = mix_c;
  assign cfg_o.one_minus_mix  = Q16One - mix_c;
  assign cfg_o.fb             = fb_q;
  assign cfg_o.len_a          = len_a_q;
  assign cfg_o.len_b          = len_b_q;
  assign cfg_o.len_p          = len_p_q;

endmodule

`default_nettype wire

>>> src/cap_frame_queue.sv
// Front end: accepts input frames into a short queue ahead of the engine.
`default_nettype none

module cap_frame_queue
  import cap_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire in_frame_t   in_data_i,
  input  wire cap_status_t status_i,
  output logic             q_valid_o,
  input  wire logic        q_ready_i,
  output in_frame_t        q_data_o
);

  in_frame_t        slot_q [QDepth];
  logic [QPtrW-1:0] wptr_q, rptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             push, pop;

  // Hold off input while the stores are being cleared
  assign in_ready_o = (cnt_q < QCntW'(QDepth)) && !status_i.clearing;
  assign q_valid_o  = (cnt_q != '0);
  assign q_data_o   = slot_q[rptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  // Store the transfer payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= in_data_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == QPtrW'(QDepth - 1)) ? '0 : wptr_q + QPtrW'(1);
      end
      if (pop) begin
        rptr_q <= (rptr_q == QPtrW'(QDepth - 1)) ? '0 : rptr_q + QPtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> src/cap_engine.sv
// Back end: delay stores, shared multiplier sequencer and output register.
`default_nettype none

module cap_engine
  import cap_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cap_cfg_t  cfg_i,
  input  wire logic      q_valid_i,
  output logic           q_ready_o,
  input  wire in_frame_t q_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_frame_t     out_data_o,
  output cap_status_t    status_o
);

  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StRead   = 4'd1;
  localparam logic [3:0] StMulCa  = 4'd2;
  localparam logic [3:0] StMulLp  = 4'd3;
  localparam logic [3:0] StLp     = 4'd4;
  localparam logic [3:0] StMulFbA = 4'd5;
  localparam logic [3:0] StWrA    = 4'd6;
  localparam logic [3:0] StWrB    = 4'd7;
  localparam logic [3:0] StMulY   = 4'd8;
  localparam logic [3:0] StOut    = 4'd9;

  logic [3:0]       state_q, state_d;
  logic [ChanW-1:0] chan_q;
  logic             last_chan;
  in_frame_t        frame_q;

  logic [PosAW-1:0] pos_a_q;
  logic [PosBW-1:0] pos_b_q;
  logic [PosPW-1:0] pos_p_q;

  logic             clr_busy_q;
  logic [ClrW-1:0]  clr_cnt_q;

  logic signed [DataW-1:0]   lp_q [CHANNELS];
  logic signed [ProdW-1:0]   prod_q;
  logic signed [AccW-1:0]    acc_q;
  logic signed [MulAW-1:0]   y_q;
  logic signed [SampleW-1:0] lane_q [LanesW];
  logic signed [SampleW-1:0] lane_v [LanesW];
  out_frame_t                out_q;
  logic                      out_valid_q;
  logic                      out_free;
  logic                      out_load;

  // Delay stores
  logic signed [DataW-1:0] mem_a [MemADepth];
  logic signed [DataW-1:0] mem_b [MemBDepth];
  logic signed [DataW-1:0] mem_p [MemPDepth];
  logic signed [DataW-1:0] rd_a_q, rd_b_q, rd_p_q;
  logic [AddrAW-1:0]       addr_a, waddr_a;
  logic [AddrBW-1:0]       addr_b, waddr_b;
  logic [AddrPW-1:0]       addr_p, waddr_p;
  logic                    we_a, we_b, we_p, rd_en;
  logic signed [DataW-1:0] wdata_a, wdata_b, wdata_p;

  // Datapath
  logic signed [MulAW-1:0]   mul_a;
  logic signed [MulBW-1:0]   mul_b;
  logic signed [ProdW-1:0]   mul_p;
  logic signed [SampleW-1:0] x;
  logic signed [AccW-1:0]    sum_w, prod_w, prod_rnd, wet_w, y_w;
  logic signed [DataW-1:0]   lp_new, new_a, new_b, new_p;
  logic signed [SampleW-1:0] out_s;

  assign last_chan = (chan_q == ChanW'(CHANNELS - 1));
  assign x = (CHANNELS > 1 && chan_q != '0) ? frame_q.right_in : frame_q.left_in;
  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = (state_q == StOut) && last_chan && out_free;

  // Interleaved addresses: position times channel count plus channel
  assign addr_a = AddrAW'(pos_a_q * CHANNELS + chan_q);
  assign addr_b = AddrBW'(pos_b_q * CHANNELS + chan_q);
  assign addr_p = AddrPW'(pos_p_q * CHANNELS + chan_q);

  // Shared multiplier operand select
  always_comb begin
    case (state_q)
      StMulCa: begin
        mul_a = MulAW'(rd_a_q);
        mul_b = MulBW'(cfg_i.one_minus_damp);
      end
      StMulLp: begin
        mul_a = MulAW'(lp_q[chan_q]);
        mul_b = MulBW'(cfg_i.damp);
      end
      StMulFbA: begin
        mul_a = MulAW'(lp_q[chan_q]);
        mul_b = MulBW'(cfg_i.fb);
      end
      StWrA: begin
        mul_a = MulAW'(rd_b_q);
        mul_b = MulBW'(cfg_i.fb);
      end
      StWrB: begin
        mul_a = MulAW'(x);
        mul_b = MulBW'(cfg_i.one_minus_mix);
      end
      StMulY: begin
        mul_a = y_q;
        mul_b = MulBW'(cfg_i.mix);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Filter arithmetic on registered products
  always_comb begin
    prod_w   = AccW'(prod_q);
    sum_w    = acc_q + prod_w;
    prod_rnd = rnd16(prod_w);
    lp_new   = sat24(rnd16(sum_w));
    new_a    = sat24(AccW'(x) + prod_rnd);
    new_b    = sat24(AccW'(x) + prod_rnd);
    wet_w    = (AccW'(rd_a_q) + AccW'(rd_b_q)) >>> 1;
    y_w      = AccW'(rd_p_q) + ((-wet_w) >>> 1);
    new_p    = sat24(wet_w + (AccW'(rd_p_q) >>> 1));
    out_s    = sat16(rnd16(sum_w));
  end

  // Memory write select: clearing pass or filter update
  always_comb begin
    rd_en   = (state_q == StRead);
    we_a    = clr_busy_q ? ({1'b0, clr_cnt_q} < (ClrW + 1)'(MemADepth)) : (state_q == StWrA);
    we_b    = clr_busy_q ? ({1'b0, clr_cnt_q} < (ClrW + 1)'(MemBDepth)) : (state_q == StWrB);
    we_p    = clr_busy_q ? ({1'b0, clr_cnt_q} < (ClrW + 1)'(MemPDepth)) : (state_q == StWrB);
    waddr_a = clr_busy_q ? clr_cnt_q[AddrAW-1:0] : addr_a;
    waddr_b = clr_busy_q ? clr_cnt_q[AddrBW-1:0] : addr_b;
    waddr_p = clr_busy_q ? clr_cnt_q[AddrPW-1:0] : addr_p;
    wdata_a = clr_busy_q ? '0 : new_a;
    wdata_b = clr_busy_q ? '0 : new_b;
    wdata_p = clr_busy_q ? '0 : new_p;
  end

  always_ff @(posedge clk_i) begin
    if (we_a) begin
      mem_a[waddr_a] <= wdata_a;
    end
    if (rd_en) begin
      rd_a_q <= mem_a[addr_a];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_b) begin
      mem_b[waddr_b] <= wdata_b;
    end
    if (rd_en) begin
      rd_b_q <= mem_b[addr_b];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_p) begin
      mem_p[waddr_p] <= wdata_p;
    end
    if (rd_en) begin
      rd_p_q <= mem_p[addr_p];
    end
  end

  // Clearing pass after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + ClrW'(1);
      if (clr_cnt_q == ClrW'(ClrLen - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  assign status_o.clearing = clr_busy_q;
  assign q_ready_o = (state_q == StIdle) && !clr_busy_q;

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:   if (q_valid_i && !clr_busy_q) state_d = StRead;
      StRead:   state_d = StMulCa;
      StMulCa:  state_d = StMulLp;
      StMulLp:  state_d = StLp;
      StLp:     state_d = StMulFbA;
      StMulFbA: state_d = StWrA;
      StWrA:    state_d = StWrB;
      StWrB:    state_d = StMulY;
      StMulY:   state_d = StOut;
      StOut: begin
        if (!last_chan) begin
          state_d = StRead;
        end else if (out_free) begin
          state_d = StIdle;
        end
      end
      default:  state_d = StIdle;
    endcase
  end

  // Collect lanes for the finished frame
  always_comb begin
    for (int k = 0; k < LanesW; k++) begin
      if (k < CHANNELS) begin
        lane_v[k] = (ChanW'(k) == chan_q) ? out_s : lane_q[k];
      end else begin
        lane_v[k] = '0;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      chan_q      <= '0;
      pos_a_q     <= '0;
      pos_b_q     <= '0;
      pos_p_q     <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < CHANNELS; k++) begin
        lp_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      // Load a finished frame, or drop valid once the result is taken
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == StIdle) begin
        chan_q <= '0;
      end
      if (state_q == StLp) begin
        lp_q[chan_q] <= lp_new;
      end
      if (state_q == StOut) begin
        if (!last_chan) begin
          chan_q <= chan_q + ChanW'(1);
        end else if (out_free) begin
          pos_a_q <= PosAW'(next_pos(LenCmpW'(pos_a_q), LenCmpW'(cfg_i.len_a),
                                     LenCmpW'(COMB_A_DEPTH)));
          pos_b_q <= PosBW'(next_pos(LenCmpW'(pos_b_q), LenCmpW'(cfg_i.len_b),
                                     LenCmpW'(COMB_B_DEPTH)));
          pos_p_q <= PosPW'(next_pos(LenCmpW'(pos_p_q), LenCmpW'(cfg_i.len_p),
                                     LenCmpW'(ALLPASS_DEPTH)));
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && q_valid_i && !clr_busy_q) begin
      frame_q <= q_data_i;
    end
    case (state_q)
      StMulCa:  prod_q <= mul_p;
      StMulLp: begin
        acc_q  <= prod_w;
        prod_q <= mul_p;
      end
      StMulFbA: prod_q <= mul_p;
      StWrA:    prod_q <= mul_p;
      StWrB: begin
        y_q    <= y_w[MulAW-1:0];
        prod_q <= mul_p;
      end
      StMulY: begin
        acc_q  <= prod_w;
        prod_q <= mul_p;
      end
      StOut: begin
        lane_q[chan_q] <= out_s;
        if (last_chan && out_free) begin
          out_q.left_out  <= lane_v[0];
          out_q.right_out <= (CHANNELS > 1) ? lane_v[1] : '0;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> src/comb_allpass_reverb_unit.sv
// Top level of the stereo comb/allpass reverb: config port, frame queue and engine.
`default_nettype none

// Stereo reverb, one Q1.15 frame in and one saturated frame out per transfer.
// Each channel runs through two feedback combs (the first with a damping
// low-pass), their average through a gain-0.5 allpass, and a dry/wet mix.
// All products go through one shared 25x18 multiplier, stepped by a sequencer
// that runs the channels in turn through read, multiply, low-pass, write and
// output steps; the engine takes the next frame from the queue only once it
// is back in idle after the last channel. A two-entry queue in front and an
// output register behind let the source and the sink stall independently.
// After reset the delay stores are zeroed by a clearing pass that spans the
// largest store, comb B (4096 frames times two channels), during which no
// input is taken; configuration writes are taken at any time.
module comb_allpass_reverb_unit
  import cap_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [PaddrW-1:0]   paddr,
  input  wire logic [ApbDataW-1:0] pwdata,
  output logic      [ApbDataW-1:0] prdata,
  output logic                     pready,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire in_frame_t           in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output out_frame_t               out_data_o
);

  cap_cfg_t    cfg;
  cap_status_t status;
  logic        q_valid, q_ready;
  in_frame_t   q_data;

  cap_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cap_frame_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .status_i   (status),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_data_o   (q_data)
  );

  cap_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_data_i    (q_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .status_o    (status)
  );

endmodule

`default_nettype wire
